// ----- sv/dsc_pkg.sv -----
package dsc_pkg;

   localparam int FACES_DEF = 6;
   localparam int VAL_W     = 30;
   localparam int THROWS_W  = 63;

   localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;
   // floor(2^60 / MODULUS), used for Barrett reduction of a 60-bit product
   localparam logic [VAL_W:0] BARRETT_MU = 31'((64'd1 << (2 * VAL_W)) / 64'(MODULUS));

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic rrow;
   } dsc_tag_type;

   typedef struct packed {
      dsc_tag_type      tag;
      logic [VAL_W-1:0] a;
   } dsc_iss_type;

   typedef struct packed {
      logic init;
      logic commit;
      logic take_row;
   } dsc_ctl_type;

   // companion matrix: sub-diagonal ones, last column all ones
   function automatic logic [VAL_W-1:0] comp_entry(input int row, input int col,
                                                   input int faces);
      logic one;
      one = (col == faces - 1) || (row == col + 1);
      return {{(VAL_W-1){1'b0}}, one};
   endfunction

   function automatic logic [VAL_W-1:0] seed_entry(input int col);
      logic [VAL_W-1:0] v;
      v = {{(VAL_W-1){1'b0}}, 1'b1};
      return v << col;
   endfunction

endpackage

// ----- sv/dsc_mulmod.sv -----
module dsc_mulmod (
   input  logic                         clock,
   input  logic                         reset,
   input  dsc_pkg::dsc_tag_type         tag_in,
   input  logic [dsc_pkg::VAL_W-1:0]    a_in,
   input  logic [dsc_pkg::VAL_W-1:0]    b_in,
   output dsc_pkg::dsc_tag_type         tag_out,
   output logic [dsc_pkg::VAL_W-1:0]    red_out
);
   import dsc_pkg::*;

   localparam int PW = 2 * VAL_W;   // product width
   localparam int RW = VAL_W + 2;   // remainder width, holds up to 3 * MODULUS

   dsc_tag_type       tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [PW-1:0]     prod1_ff;
   logic [RW-1:0]     x2_ff, x3_ff, qp3_ff;
   logic [VAL_W:0]    q2_ff;
   logic [VAL_W-1:0]  red4_ff;

   logic [PW-1:0]     prod_in;
   logic [PW+1:0]     qm;
   logic [PW:0]       qp;
   logic [RW-1:0]     diff;
   logic [VAL_W-1:0]  red_in;

   assign prod_in = {{VAL_W{1'b0}}, a_in} * {{VAL_W{1'b0}}, b_in};
   assign qm      = {{(VAL_W+1){1'b0}}, prod1_ff[PW-1:VAL_W-1]}
                  * {{(VAL_W+1){1'b0}}, BARRETT_MU};
   assign qp      = {{VAL_W{1'b0}}, q2_ff} * {{(VAL_W+1){1'b0}}, MODULUS};
   assign diff    = x3_ff - qp3_ff;

   always_comb begin
      if (diff >= ({2'b00, MODULUS} << 1)) begin
         red_in = VAL_W'(diff - ({2'b00, MODULUS} << 1));
      end else if (diff >= {2'b00, MODULUS}) begin
         red_in = VAL_W'(diff - {2'b00, MODULUS});
      end else begin
         red_in = diff[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
      prod1_ff <= prod_in;
      x2_ff    <= prod1_ff[RW-1:0];
      q2_ff    <= qm[PW+1:VAL_W+1];
      x3_ff    <= x2_ff;
      qp3_ff   <= qp[RW-1:0];
      red4_ff  <= red_in;
   end

   assign tag_out = tag4_ff;
   assign red_out = red4_ff;

endmodule

// ----- sv/dsc_cell.sv -----
module dsc_cell #(
   parameter int FACES = dsc_pkg::FACES_DEF,
   parameter int IDX   = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dsc_pkg::dsc_iss_type         iss_in,
   output dsc_pkg::dsc_iss_type         iss_out,
   input  dsc_pkg::dsc_ctl_type         ctl,
   input  logic [$clog2(FACES)-1:0]     rd_idx,
   output logic [dsc_pkg::VAL_W-1:0]    rd_val,
   output logic [dsc_pkg::VAL_W-1:0]    row_val,
   output logic                         done
);
   import dsc_pkg::*;

   logic [VAL_W-1:0] col_ff  [FACES];
   logic [VAL_W-1:0] ring_ff [FACES];
   logic [VAL_W-1:0] nxt_ff  [FACES];
   logic [VAL_W-1:0] row_ff, rnew_ff, acc_ff;
   logic [VAL_W-1:0] a_ff, b_ff;
   dsc_tag_type      tag0_ff;
   dsc_iss_type      iss_out_ff;
   logic             done_ff;

   dsc_tag_type      tag4;
   logic [VAL_W-1:0] red4;
   logic [VAL_W:0]   sum;
   logic [VAL_W-1:0] sum_red;

   dsc_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag0_ff),
      .a_in    (a_ff),
      .b_in    (b_ff),
      .tag_out (tag4),
      .red_out (red4)
   );

   assign sum     = (tag4.first ? {(VAL_W+1){1'b0}} : {1'b0, acc_ff}) + {1'b0, red4};
   assign sum_red = (sum >= {1'b0, MODULUS}) ? VAL_W'(sum - {1'b0, MODULUS})
                                             : sum[VAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff.valid          <= 1'b0;
         iss_out_ff.tag.valid   <= 1'b0;
         done_ff                <= 1'b0;
      end else begin
         tag0_ff    <= iss_in.tag;
         iss_out_ff <= iss_in;
         if (tag4.valid && tag4.last && tag4.rrow) begin
            done_ff <= 1'b1;
         end
         if (ctl.init || ctl.commit) begin
            done_ff <= 1'b0;
         end
      end

      a_ff <= iss_in.a;
      // rotate the working copy so element k sits at the head on step k
      if (iss_in.tag.valid) begin
         b_ff <= ring_ff[0];
         for (int m = 0; m < FACES - 1; m++) begin
            ring_ff[m] <= ring_ff[m+1];
         end
         ring_ff[FACES-1] <= ring_ff[0];
      end

      if (tag4.valid) begin
         acc_ff <= sum_red;
         if (tag4.last) begin
            if (tag4.rrow) begin
               rnew_ff <= sum_red;
            end else begin
               for (int m = 0; m < FACES - 1; m++) begin
                  nxt_ff[m] <= nxt_ff[m+1];
               end
               nxt_ff[FACES-1] <= sum_red;
            end
         end
      end

      if (ctl.init) begin
         for (int m = 0; m < FACES; m++) begin
            col_ff[m]  <= comp_entry(m, IDX, FACES);
            ring_ff[m] <= comp_entry(m, IDX, FACES);
         end
         row_ff <= seed_entry(IDX);
      end else if (ctl.commit) begin
         for (int m = 0; m < FACES; m++) begin
            col_ff[m]  <= nxt_ff[m];
            ring_ff[m] <= nxt_ff[m];
         end
         if (ctl.take_row) begin
            row_ff <= rnew_ff;
         end
      end
   end

   assign iss_out = iss_out_ff;
   assign rd_val  = col_ff[rd_idx];
   assign row_val = row_ff;
   assign done    = done_ff;

endmodule

// ----- sv/dice_sum_count_matrix_power.sv -----
// Dice sum counter: number of ordered die sequences (faces 1..FACES) summing to
// the requested throw count, modulo 1000000007.
// Input channel req_valid/req_ready/req_throws; result channel
// rsp_valid/rsp_ready/rsp_ways_mod. One result per item, in order.
// Zero throws gives 1; up to FACES throws gives 2^(n-1), ready the cycle after
// the item is taken. Larger counts run square-and-multiply over the bits of
// n-FACES on a chain of FACES cells, each holding one column of the power
// matrix and the matching element of the running row vector. Every pass feeds
// FACES+1 dot products of FACES steps through the chain (the rows of the
// square plus the row-vector product), then drains the chain and the modular
// multiplier pipeline in each cell; there is one pass per bit of n-FACES.
// One item is in work at a time. A finished result sits in an output register;
// while the receiver stalls it is held and no new item is taken.
// Reset is synchronous and returns the block to idle; no clearing pass.
module dice_sum_count_matrix_power #(
   parameter int FACES = dsc_pkg::FACES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dsc_pkg::THROWS_W-1:0]    req_throws,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dsc_pkg::VAL_W-1:0]       rsp_ways_mod
);
   import dsc_pkg::*;

   localparam int IW = $clog2(FACES);
   localparam int IC = $clog2(FACES + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_ISSUE, ST_WAIT, ST_COMMIT, ST_FINISH
   } state_type;

   state_type             state_ff;
   dsc_ctl_type           ctl_ff;
   dsc_iss_type           iss_ff;
   logic [IC-1:0]         i_ff;
   logic [IW-1:0]         k_ff;
   logic [THROWS_W-1:0]   e_ff;
   logic [VAL_W-1:0]      rv_ff [FACES-1];
   logic                  rsp_valid_ff;
   logic [VAL_W-1:0]      rsp_ways_ff;

   dsc_iss_type           chain [FACES+1];
   logic [VAL_W-1:0]      cell_rd  [FACES];
   logic [VAL_W-1:0]      cell_row [FACES];
   logic                  cell_done [FACES];
   logic [VAL_W-1:0]      src [FACES];

   logic                  rrow_now;
   logic                  is_small;
   logic [IC-1:0]         nsmall;
   logic [VAL_W-1:0]      small_val;

   assign chain[0] = iss_ff;

   for (genvar j = 0; j < FACES; j++) begin : g_cell
      dsc_cell #(.FACES(FACES), .IDX(j)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .iss_in  (chain[j]),
         .iss_out (chain[j+1]),
         .ctl     (ctl_ff),
         .rd_idx  (i_ff[IW-1:0]),
         .rd_val  (cell_rd[j]),
         .row_val (cell_row[j]),
         .done    (cell_done[j])
      );
   end

   assign rrow_now = (i_ff == IC'(FACES));

   always_comb begin
      for (int j = 0; j < FACES; j++) begin
         src[j] = rrow_now ? cell_row[j] : cell_rd[j];
      end
   end

   assign is_small  = (req_throws <= THROWS_W'(FACES));
   assign nsmall    = req_throws[IC-1:0];
   assign small_val = {{(VAL_W-1){1'b0}}, 1'b1} << (nsmall - IC'(1));

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         ctl_ff           <= '0;
         iss_ff.tag.valid <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         ctl_ff           <= '0;
         iss_ff.tag.valid <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  i_ff <= '0;
                  k_ff <= '0;
                  e_ff <= req_throws - THROWS_W'(FACES);
                  if (req_throws == '0) begin
                     rsp_ways_ff  <= {{(VAL_W-1){1'b0}}, 1'b1};
                     rsp_valid_ff <= 1'b1;
                  end else if (is_small) begin
                     rsp_ways_ff  <= small_val;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     ctl_ff.init <= 1'b1;
                     state_ff    <= ST_INIT;
                  end
               end
            end
            ST_INIT: begin
               state_ff <= ST_ISSUE;
            end
            ST_ISSUE: begin
               iss_ff.tag.valid <= 1'b1;
               iss_ff.tag.first <= (k_ff == '0);
               iss_ff.tag.last  <= (k_ff == IW'(FACES - 1));
               iss_ff.tag.rrow  <= rrow_now;
               iss_ff.a         <= (k_ff == '0) ? src[0] : rv_ff[0];
               // load the source row at step zero, then shift it toward the head
               for (int m = 0; m < FACES - 2; m++) begin
                  rv_ff[m] <= (k_ff == '0) ? src[m+1] : rv_ff[m+1];
               end
               if (k_ff == '0) begin
                  rv_ff[FACES-2] <= src[FACES-1];
               end
               if (k_ff == IW'(FACES - 1)) begin
                  k_ff <= '0;
                  if (rrow_now) begin
                     i_ff     <= '0;
                     state_ff <= ST_WAIT;
                  end else begin
                     i_ff <= i_ff + IC'(1);
                  end
               end else begin
                  k_ff <= k_ff + IW'(1);
               end
            end
            ST_WAIT: begin
               if (cell_done[FACES-1]) begin
                  ctl_ff.commit   <= 1'b1;
                  ctl_ff.take_row <= e_ff[0];
                  e_ff            <= e_ff >> 1;
                  state_ff        <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               state_ff <= (e_ff == '0) ? ST_FINISH : ST_ISSUE;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ways_ff  <= cell_row[FACES-1];
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ways_mod = rsp_ways_ff;

   a_issue_only_in_issue: assert property (@(posedge clock) disable iff (reset)
      iss_ff.tag.valid |-> $past(state_ff == ST_ISSUE))
      else $error("issue slot valid outside the issue state");

   a_ctl_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ctl_ff.init && ctl_ff.commit))
      else $error("init and commit together");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      cell_done[FACES-1] |-> (state_ff == ST_WAIT || state_ff == ST_COMMIT))
      else $error("chain finished a pass outside the wait state");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import dsc_pkg::*;

   localparam int FACES = FACES_DEF;
   localparam longint unsigned PRIME = 64'd1000000007;

   typedef struct {
      logic [THROWS_W-1:0] throws;
      bit                  known;
      logic [VAL_W-1:0]    ways;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [THROWS_W-1:0] req_throws;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [VAL_W-1:0]    rsp_ways_mod;

   logic [VAL_W-1:0] ways_queue[$];
   int               mismatches;
   int               results_seen;
   int               items_sent;
   int               long_stall;
   bit               stim_done;

   dice_sum_count_matrix_power #(.FACES(FACES)) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_throws   (req_throws),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_ways_mod (rsp_ways_mod)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // row vector times power of the companion matrix, square-and-multiply
   function automatic logic [VAL_W-1:0] count_ways(input logic [THROWS_W-1:0] n);
      longint unsigned vec[FACES];
      longint unsigned mat[FACES][FACES];
      longint unsigned tmp[FACES][FACES];
      longint unsigned nv[FACES];
      longint unsigned acc;
      logic [THROWS_W-1:0] e;
      if (n == 0) return VAL_W'(1);
      for (int i = 0; i < FACES; i++) vec[i] = 64'd1 << i;
      if (n <= THROWS_W'(FACES)) return VAL_W'(vec[n-1]);
      for (int i = 0; i < FACES; i++)
         for (int j = 0; j < FACES; j++)
            mat[i][j] = (j == FACES - 1 || i == j + 1) ? 1 : 0;
      e = n - THROWS_W'(FACES);
      while (e != 0) begin
         if (e[0]) begin
            for (int j = 0; j < FACES; j++) begin
               acc = 0;
               for (int i = 0; i < FACES; i++) acc = (acc + vec[i] * mat[i][j] % PRIME) % PRIME;
               nv[j] = acc;
            end
            vec = nv;
         end
         e = e >> 1;
         if (e != 0) begin
            for (int i = 0; i < FACES; i++)
               for (int j = 0; j < FACES; j++) begin
                  acc = 0;
                  for (int k = 0; k < FACES; k++)
                     acc = (acc + mat[i][k] * mat[k][j] % PRIME) % PRIME;
                  tmp[i][j] = acc;
               end
            mat = tmp;
         end
      end
      return VAL_W'(vec[FACES-1]);
   endfunction

   function automatic int short_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                         : $urandom_range(0, 3);
   endfunction

   task automatic send_throws(input logic [THROWS_W-1:0] n, input bit known,
                              input logic [VAL_W-1:0] ways);
      req_valid  <= 1'b1;
      req_throws <= n;
      ways_queue.push_back(known ? ways : count_ways(n));
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic logic [THROWS_W-1:0] rand_throws();
      logic [THROWS_W-1:0] v;
      int pick;
      v    = THROWS_W'({$urandom, $urandom});
      pick = $urandom_range(0, 9);
      if (pick < 3) return THROWS_W'($urandom_range(0, 40));
      if (pick < 6) return v >> $urandom_range(40, 56);
      if (pick < 8) return v >> $urandom_range(20, 39);
      return v;
   endfunction

   // stimulus
   initial begin
      dir_row_type dir_rows[$];
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_throws <= '0;
      stim_done   = 0;
      items_sent  = 0;
      long_stall  = 0;
      dir_rows = '{
         '{63'd0, 1, 30'd1},  '{63'd1, 1, 30'd1},  '{63'd2, 1, 30'd2},
         '{63'd3, 1, 30'd4},  '{63'd4, 1, 30'd8},  '{63'd5, 1, 30'd16},
         '{63'd6, 1, 30'd32}, '{63'd7, 1, 30'd63}, '{63'd8, 1, 30'd125},
         '{63'd9, 1, 30'd248}, '{63'd12, 0, '0},   '{63'd50, 0, '0},
         '{63'h7FFFFFFFFFFFFFFF, 0, '0}, '{63'h7FFFFFFFFFFFFFFE, 0, '0},
         '{63'h4000000000000000, 0, '0}, '{63'h2AAAAAAAAAAAAAAA, 0, '0},
         '{63'h5555555555555555, 0, '0}, '{63'd1000000013, 0, '0}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) send_throws(dir_rows[i].throws, dir_rows[i].known,
                                        dir_rows[i].ways);
      // start a long receiver hold-off while items keep coming
      long_stall = 8000;
      for (int i = 0; i < 600; i++) begin
         send_throws(rand_throws(), 0, '0);
         if ($urandom_range(0, 2) == 0) idle_sender(short_gap());
         if (i == 300) begin
            req_valid <= 1'b0;
            while (ways_queue.size() != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      stim_done  = 1;
   end

   // result side
   initial begin
      logic [VAL_W-1:0] want;
      mismatches   = 0;
      results_seen = 0;
      rsp_ready   <= 1'b0;
      @(posedge clock);
      while (!stim_done || ways_queue.size() != 0) begin
         if (long_stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (long_stall) @(posedge clock);
            long_stall = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (short_gap() + 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (ways_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %0d", rsp_ways_mod);
            end else begin
               want = ways_queue.pop_front();
               if (rsp_ways_mod !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ways_mod mismatch: expected %0d, got %0d", want, rsp_ways_mod);
               end
            end
         end
      end
      rsp_ready <= 1'b1;
      repeat (100) begin
         @(posedge clock);
         if (rsp_valid) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d", rsp_ways_mod);
         end
      end
      $display("covered %0d items from zero up to 2^63-1, %0d results checked",
               items_sent, results_seen);
      if (mismatches == 0 && ways_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
